// File: hw/rtl/m2p_pkg.sv
// Shared constants, types and codes for the magnetometer-to-pointer block.
package m2p_pkg;

	localparam int POS_BITS  = 12;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 16;
	// 2v - lo - hi needs two more bits than a sample, hi - lo one more
	localparam int NUM_W     = DATA_W + 2;
	localparam int DEN_W     = DATA_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [DATA_W-1:0] X_LO_RST = -16'sd5000;
	localparam logic signed [DATA_W-1:0] X_HI_RST = 16'sd5000;
	localparam logic signed [DATA_W-1:0] Y_LO_RST = -16'sd5000;
	localparam logic signed [DATA_W-1:0] Y_HI_RST = 16'sd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LO,
		REG_X_HI,
		REG_Y_LO,
		REG_Y_HI
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_NX,
		ST_NY,
		ST_FX,
		ST_FY,
		ST_CLAMP,
		ST_MAP,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_req_t;

endpackage

// File: hw/rtl/m2p_if.sv
// Request channel interfaces: magnetometer samples in, pointer positions out.
interface m2p_mag_if;
	logic                                valid;
	logic                                ready;
	logic signed [m2p_pkg::DATA_W-1:0]   field_x;
	logic signed [m2p_pkg::DATA_W-1:0]   field_y;
	logic                                hold;

	modport source(output valid, output field_x, output field_y, output hold, input ready);
	modport sink(input valid, input field_x, input field_y, input hold, output ready);
endinterface

interface m2p_ptr_if #(
	parameter int POS_BITS = m2p_pkg::POS_BITS
);
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] pointer_x;
	logic [POS_BITS-1:0] pointer_y;

	modport source(output valid, output pointer_x, output pointer_y, input ready);
	modport sink(input valid, input pointer_x, input pointer_y, output ready);
endinterface

// File: hw/rtl/m2p_div.sv
// Bit-serial signed fractional divider: trunc(num * 2^FRAC_BITS / den), clamped to +-1.
module m2p_div #(
	parameter int FRAC_BITS = m2p_pkg::FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  m2p_pkg::div_req_t          req,
	output logic                       done,
	output logic signed [FRAC_BITS+1:0] quot
);
	localparam int NW = m2p_pkg::NUM_W;
	localparam int DW = m2p_pkg::DEN_W;
	localparam int QW = FRAC_BITS + 2;
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [QW-1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};

	logic [NW-1:0]        mag_n;
	logic [DW-1:0]        mag_d;
	logic                 neg;
	logic                 quick;
	logic [DW:0]          r2;
	logic                 ge;
	logic [DW:0]          r_next;
	logic [FRAC_BITS-1:0] fr_next;
	logic [QW-1:0]        ext;

	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        d_q;
	logic [FRAC_BITS-1:0] fr_q;
	logic                 neg_q;
	logic [QW-1:0]        quot_q;

	always_comb begin
		mag_n   = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
		mag_d   = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
		neg     = req.num[NW-1] ^ req.den[DW-1];
		// |num| >= |den| means the quotient reaches one: saturate (covers den == 0)
		quick   = (req.num == '0) || (mag_n >= NW'(mag_d));
		r2      = {rem_q, 1'b0};
		ge      = r2 >= {1'b0, d_q};
		r_next  = ge ? (r2 - {1'b0, d_q}) : r2;
		fr_next = {fr_q[FRAC_BITS-2:0], ge};
		ext     = {2'b00, fr_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= req.start ? quick : (busy_q && (cnt_q == CW'(1)));
			if (req.start) begin
				if (!quick) begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= mag_n[DW-1:0];
			d_q   <= mag_d;
			neg_q <= neg;
			fr_q  <= '0;
			if (req.num == '0) begin
				quot_q <= '0;
			end else begin
				quot_q <= neg ? (~ONE_Q + 1'b1) : ONE_Q;
			end
		end else if (busy_q) begin
			rem_q <= r_next[DW-1:0];
			fr_q  <= fr_next;
			if (cnt_q == CW'(1)) begin
				quot_q <= neg_q ? (~ext + 1'b1) : ext;
			end
		end
	end

	assign done = done_q;
	assign quot = signed'(quot_q);

endmodule

// File: hw/rtl/mag_to_pointer_position.sv
// Top level: magnetometer sample to pointer position, with hold and re-centering.
//
//   channel  dir  payload                      handshake
//   mag      in   field_x, field_y, hold       valid / ready
//   ptr      out  pointer_x, pointer_y         valid / ready
//   cfg      in   cfg_idx, cfg_data            cfg_we, no wait
//
// A moving sample runs the one bit-serial divider once per axis; the first sample after
// a hold runs it twice more for the re-centering offsets. A held sample skips the
// divider and reissues the last position.
// Reset restores the limit registers, clears offsets and centers the pointer.
// A result waits in the output register; the block stalls before loading it while the
// previous one is still untaken, and takes a new request only from idle.
module mag_to_pointer_position #(
	parameter int POS_BITS  = m2p_pkg::POS_BITS,
	parameter int FRAC_BITS = m2p_pkg::FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	m2p_mag_if.sink                             mag,
	m2p_ptr_if.source                           ptr,
	input  logic                                cfg_we,
	input  logic [m2p_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [m2p_pkg::DATA_W-1:0]          cfg_data
);
	localparam int DATA_W  = m2p_pkg::DATA_W;
	localparam int NUM_W   = m2p_pkg::NUM_W;
	localparam int DEN_W   = m2p_pkg::DEN_W;
	localparam int NORM_W  = FRAC_BITS + 2;
	localparam int SHIFT_W = FRAC_BITS + 3;
	localparam int PROD_W  = NORM_W + POS_BITS;

	localparam logic [POS_BITS-1:0] MAX_POS = '1;
	localparam logic [POS_BITS-1:0] MID_POS = {1'b1, {(POS_BITS-1){1'b0}}};
	localparam logic signed [SHIFT_W-1:0] ONE_S = {3'b001, {FRAC_BITS{1'b0}}};
	localparam logic signed [NORM_W-1:0]  ONE_N = {2'b01, {FRAC_BITS{1'b0}}};

	function automatic logic signed [NORM_W-1:0] clamp_one(input logic signed [SHIFT_W-1:0] v);
		logic signed [NORM_W-1:0] r;
		if (v > ONE_S) begin
			r = ONE_N;
		end else if (v < -ONE_S) begin
			r = -ONE_N;
		end else begin
			r = NORM_W'(v);
		end
		return r;
	endfunction

	// floor((n + 1) * MAX_POS / 2), with n in [-1, 1]
	function automatic logic [POS_BITS-1:0] to_pos(input logic signed [NORM_W-1:0] n);
		logic [NORM_W-1:0] u;
		logic [PROD_W-1:0] prod;
		u    = NORM_W'(n + ONE_N);
		prod = {u, {POS_BITS{1'b0}}} - PROD_W'(u);
		return prod[FRAC_BITS+1 +: POS_BITS];
	endfunction

	m2p_pkg::seq_state_t state_q, state_d;
	m2p_pkg::div_req_t   div_req;
	logic                div_done;
	logic signed [NORM_W-1:0] div_quot;

	logic signed [DATA_W-1:0]  x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic signed [SHIFT_W-1:0] shift_x_q, shift_y_q;
	logic [POS_BITS-1:0]       last_x_q, last_y_q;
	logic                      held_before_q;
	logic                      out_valid_q;
	logic [POS_BITS-1:0]       px_q, py_q;

	logic signed [DATA_W-1:0]  vx_q, vy_q;
	logic signed [NORM_W-1:0]  nx_q, ny_q, fx_q, ncx_q, ncy_q;

	logic signed [NUM_W-1:0]   num_x, num_y, num_fx, num_fy;
	logic signed [DEN_W-1:0]   den_x, den_y, den_f;
	logic                      accept;
	logic                      out_load;

	assign accept   = mag.valid && (state_q == m2p_pkg::ST_IDLE);
	assign out_load = (state_q == m2p_pkg::ST_OUT) && (!out_valid_q || ptr.ready);

	always_comb begin
		num_x  = (NUM_W'(vx_q) <<< 1) - NUM_W'(x_lo_q) - NUM_W'(x_hi_q);
		num_y  = (NUM_W'(vy_q) <<< 1) - NUM_W'(y_lo_q) - NUM_W'(y_hi_q);
		den_x  = DEN_W'(x_hi_q) - DEN_W'(x_lo_q);
		den_y  = DEN_W'(y_hi_q) - DEN_W'(y_lo_q);
		num_fx = signed'(NUM_W'({last_x_q, 1'b0})) - signed'(NUM_W'(MAX_POS));
		num_fy = signed'(NUM_W'({last_y_q, 1'b0})) - signed'(NUM_W'(MAX_POS));
		den_f  = signed'(DEN_W'(MAX_POS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m2p_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = num_x;
		div_req.den   = den_x;
		case (state_q)
			m2p_pkg::ST_NX: begin
				div_req.num = num_y;
				div_req.den = den_y;
			end
			m2p_pkg::ST_NY: begin
				div_req.num = num_fx;
				div_req.den = den_f;
			end
			m2p_pkg::ST_FX: begin
				div_req.num = num_fy;
				div_req.den = den_f;
			end
			default: begin
				div_req.num = num_x;
				div_req.den = den_x;
			end
		endcase

		case (state_q)
			m2p_pkg::ST_IDLE: begin
				if (mag.valid) begin
					state_d = mag.hold ? m2p_pkg::ST_OUT : m2p_pkg::ST_START;
				end
			end
			m2p_pkg::ST_START: begin
				div_req.start = 1'b1;
				state_d       = m2p_pkg::ST_NX;
			end
			m2p_pkg::ST_NX: begin
				if (div_done) begin
					div_req.start = 1'b1;
					state_d       = m2p_pkg::ST_NY;
				end
			end
			m2p_pkg::ST_NY: begin
				if (div_done) begin
					if (held_before_q) begin
						div_req.start = 1'b1;
						state_d       = m2p_pkg::ST_FX;
					end else begin
						state_d = m2p_pkg::ST_CLAMP;
					end
				end
			end
			m2p_pkg::ST_FX: begin
				if (div_done) begin
					div_req.start = 1'b1;
					state_d       = m2p_pkg::ST_FY;
				end
			end
			m2p_pkg::ST_FY: begin
				if (div_done) begin
					state_d = m2p_pkg::ST_CLAMP;
				end
			end
			m2p_pkg::ST_CLAMP: begin
				state_d = m2p_pkg::ST_MAP;
			end
			m2p_pkg::ST_MAP: begin
				state_d = m2p_pkg::ST_OUT;
			end
			m2p_pkg::ST_OUT: begin
				if (!out_valid_q || ptr.ready) begin
					state_d = m2p_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = m2p_pkg::ST_IDLE;
			end
		endcase
	end

	m2p_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quot  (div_quot)
	);

	// architectural state and limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo_q        <= m2p_pkg::X_LO_RST;
			x_hi_q        <= m2p_pkg::X_HI_RST;
			y_lo_q        <= m2p_pkg::Y_LO_RST;
			y_hi_q        <= m2p_pkg::Y_HI_RST;
			shift_x_q     <= '0;
			shift_y_q     <= '0;
			last_x_q      <= MID_POS;
			last_y_q      <= MID_POS;
			held_before_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (m2p_pkg::cfg_reg_t'(cfg_idx))
					m2p_pkg::REG_X_LO: x_lo_q <= signed'(cfg_data);
					m2p_pkg::REG_X_HI: x_hi_q <= signed'(cfg_data);
					m2p_pkg::REG_Y_LO: y_lo_q <= signed'(cfg_data);
					m2p_pkg::REG_Y_HI: y_hi_q <= signed'(cfg_data);
					default: begin
					end
				endcase
			end
			if (accept && mag.hold) begin
				held_before_q <= 1'b1;
			end
			if ((state_q == m2p_pkg::ST_FY) && div_done) begin
				// offset so the current sample lands on the frozen position
				shift_x_q     <= SHIFT_W'(nx_q) - SHIFT_W'(fx_q);
				shift_y_q     <= SHIFT_W'(ny_q) - SHIFT_W'(div_quot);
				held_before_q <= 1'b0;
			end
			if (state_q == m2p_pkg::ST_MAP) begin
				last_x_q <= to_pos(ncx_q);
				last_y_q <= to_pos(ncy_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (ptr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= mag.field_x;
			vy_q <= mag.field_y;
		end
		if ((state_q == m2p_pkg::ST_NX) && div_done) begin
			nx_q <= div_quot;
		end
		if ((state_q == m2p_pkg::ST_NY) && div_done) begin
			ny_q <= div_quot;
		end
		if ((state_q == m2p_pkg::ST_FX) && div_done) begin
			fx_q <= div_quot;
		end
		if (state_q == m2p_pkg::ST_CLAMP) begin
			ncx_q <= clamp_one(SHIFT_W'(nx_q) - shift_x_q);
			ncy_q <= clamp_one(SHIFT_W'(ny_q) - shift_y_q);
		end
		if (out_load) begin
			px_q <= last_x_q;
			py_q <= last_y_q;
		end
	end

	assign mag.ready     = (state_q == m2p_pkg::ST_IDLE);
	assign ptr.valid     = out_valid_q;
	assign ptr.pointer_x = px_q;
	assign ptr.pointer_y = py_q;

endmodule

// File: sim/mag_to_pointer_position_test.sv
// Self-checking testbench for mag_to_pointer_position: random requests, predicted pointer positions.
module mag_to_pointer_position_test;
	import m2p_pkg::*;

	localparam int     PB        = POS_BITS;
	localparam int     FB        = FRAC_BITS;
	localparam longint UNIT      = longint'(1) << FB;
	localparam longint POS_TOP   = (longint'(1) << PB) - 1;
	localparam int     RUN_LIMIT = 1000000;

	typedef struct packed {
		logic signed [DATA_W-1:0] fx;
		logic signed [DATA_W-1:0] fy;
		logic                     hold;
	} mag_sample_t;

	typedef struct packed {
		logic [PB-1:0] px;
		logic [PB-1:0] py;
	} ptr_pos_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0]    cfg_data;

	m2p_mag_if mag_ch();
	m2p_ptr_if ptr_ch();

	mag_to_pointer_position dut (
		.clk(clk),
		.arst_n(arst_n),
		.mag(mag_ch),
		.ptr(ptr_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// predictor state and its copy of the limit registers
	logic signed [DATA_W-1:0] limit_reg [4];
	longint                   offs_x, offs_y;
	logic [PB-1:0]            prev_px, prev_py;
	bit                       was_held;

	mag_sample_t sample_q [$];
	ptr_pos_t    expect_q [$];

	int send_gap     = 0;
	int take_gap     = 0;
	int results_seen = 0;
	int err_cnt      = 0;
	int cycle_cnt    = 0;
	bit idle_on      = 1'b1;
	logic choke;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clamp_unit(input longint v);
		if (v > UNIT)
			return UNIT;
		if (v < -UNIT)
			return -UNIT;
		return v;
	endfunction

	function automatic longint axis_norm(input longint v, input longint lo, input longint hi);
		longint num;
		longint den;
		num = 2 * v - lo - hi;
		den = hi - lo;
		// collapsed range: only the sign of the numerator counts
		if (den == 0)
			return (num > 0) ? UNIT : ((num < 0) ? -UNIT : 0);
		return clamp_unit((num * UNIT) / den);
	endfunction

	function automatic longint frozen_unit(input logic [PB-1:0] pos);
		return ((2 * longint'(pos) - POS_TOP) * UNIT) / POS_TOP;
	endfunction

	function automatic logic [PB-1:0] unit_to_pos(input longint n);
		longint p;
		p = ((n + UNIT) * POS_TOP) / (2 * UNIT);
		return p[PB-1:0];
	endfunction

	function automatic ptr_pos_t predict_pointer(input mag_sample_t s);
		longint   nx;
		longint   ny;
		ptr_pos_t r;
		if (s.hold) begin
			was_held = 1'b1;
			r.px = prev_px;
			r.py = prev_py;
			return r;
		end
		nx = axis_norm(longint'($signed(s.fx)), longint'($signed(limit_reg[REG_X_LO])),
			longint'($signed(limit_reg[REG_X_HI])));
		ny = axis_norm(longint'($signed(s.fy)), longint'($signed(limit_reg[REG_Y_LO])),
			longint'($signed(limit_reg[REG_Y_HI])));
		// first sample after a hold: re-center so it lands on the frozen position
		if (was_held) begin
			offs_x = nx - frozen_unit(prev_px);
			offs_y = ny - frozen_unit(prev_py);
			was_held = 1'b0;
		end
		prev_px = unit_to_pos(clamp_unit(nx - offs_x));
		prev_py = unit_to_pos(clamp_unit(ny - offs_y));
		r.px = prev_px;
		r.py = prev_py;
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	function automatic int rand16();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// mostly near the configured span, sometimes the limits themselves or anything at all
	function automatic int pick_field(input logic signed [DATA_W-1:0] lo,
		input logic signed [DATA_W-1:0] hi);
		int a;
		int b;
		int v;
		a = (lo < hi) ? int'(lo) : int'(hi);
		b = (lo < hi) ? int'(hi) : int'(lo);
		case ($urandom_range(0, 9))
			0: v = rand16();
			1: v = lo;
			2: v = hi;
			default: v = a - 500 + int'($urandom_range(0, b - a + 1000));
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	task automatic queue_sample(input int fx, input int fy, input bit hold);
		mag_sample_t s;
		s.fx = fx[DATA_W-1:0];
		s.fy = fy[DATA_W-1:0];
		s.hold = hold;
		sample_q.push_back(s);
	endtask

	task automatic write_limit(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg[idx] = val;
	endtask

	task automatic random_limits(input cfg_reg_t lo_idx, input cfg_reg_t hi_idx);
		int ctr;
		int half;
		int lo;
		int hi;
		int t;
		case ($urandom_range(0, 9))
			0: begin
				lo = rand16();
				hi = lo;
			end
			1: begin
				lo = 32767;
				hi = -32768;
			end
			2: begin
				lo = -32768;
				hi = 32767;
			end
			3: begin
				lo = rand16();
				hi = rand16();
			end
			default: begin
				ctr = int'($urandom_range(0, 6000)) - 3000;
				half = $urandom_range(1, 12000);
				lo = ctr - half;
				hi = ctr + half;
				if ($urandom_range(0, 5) == 0) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end
		endcase
		write_limit(lo_idx, lo[DATA_W-1:0]);
		write_limit(hi_idx, hi[DATA_W-1:0]);
	endtask

	// block idle: nothing queued, nothing offered, nothing outstanding
	task automatic settle();
		while (sample_q.size() != 0 || mag_ch.valid || expect_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		mag_sample_t acc;
		mag_sample_t nxt;
		if (arst_n) begin
			if (mag_ch.valid && mag_ch.ready) begin
				acc.fx = mag_ch.field_x;
				acc.fy = mag_ch.field_y;
				acc.hold = mag_ch.hold;
				expect_q.push_back(predict_pointer(acc));
			end
			if (!mag_ch.valid || mag_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					mag_ch.valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					nxt = sample_q.pop_front();
					mag_ch.valid <= 1'b1;
					mag_ch.field_x <= nxt.fx;
					mag_ch.field_y <= nxt.fy;
					mag_ch.hold <= nxt.hold;
					send_gap = draw_gap();
				end else begin
					mag_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		ptr_pos_t want;
		if (arst_n) begin
			if (ptr_ch.valid && ptr_ch.ready) begin
				results_seen++;
				if (expect_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected pointer result x=%0d y=%0d", ptr_ch.pointer_x,
							ptr_ch.pointer_y);
				end else begin
					want = expect_q.pop_front();
					if (ptr_ch.pointer_x !== want.px || ptr_ch.pointer_y !== want.py) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("pointer mismatch #%0d: expected x=%0d y=%0d, got x=%0d y=%0d",
								results_seen, want.px, want.py, ptr_ch.pointer_x,
								ptr_ch.pointer_y);
					end
				end
				take_gap = draw_gap();
			end
			if (choke) begin
				ptr_ch.ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				ptr_ch.ready <= 1'b0;
			end else begin
				ptr_ch.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off while requests keep coming
	initial begin
		choke = 1'b0;
		wait (results_seen >= 150);
		while (sample_q.size() < 10)
			@(negedge clk);
		@(posedge clk);
		choke <= 1'b1;
		repeat (600) @(posedge clk);
		choke <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("mag_to_pointer_position test failed");
			$finish;
		end
	end

	initial begin
		int ph;
		int left;
		int kind;
		int burst;
		arst_n = 1'b0;
		mag_ch.valid = 1'b0;
		mag_ch.field_x = '0;
		mag_ch.field_y = '0;
		mag_ch.hold = 1'b0;
		ptr_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_X_LO;
		cfg_data = '0;
		limit_reg[REG_X_LO] = X_LO_RST;
		limit_reg[REG_X_HI] = X_HI_RST;
		limit_reg[REG_Y_LO] = Y_LO_RST;
		limit_reg[REG_Y_HI] = Y_HI_RST;
		offs_x = 0;
		offs_y = 0;
		prev_px = 12'd2048;
		prev_py = 12'd2048;
		was_held = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset limits: center, field extremes, span edges, hold then re-center
		@(negedge clk);
		queue_sample(0, 0, 0);
		queue_sample(32767, -32768, 0);
		queue_sample(-32768, 32767, 0);
		queue_sample(5000, -5000, 0);
		queue_sample(-4999, 4999, 0);
		queue_sample(2500, -2500, 0);
		queue_sample(123, 456, 1);
		queue_sample(-32768, -32768, 1);
		queue_sample(-4000, 3000, 0);
		queue_sample(0, 0, 0);
		queue_sample(32767, 32767, 0);
		queue_sample(-32768, -32768, 0);
		settle();

		// collapsed range on both axes
		write_limit(REG_X_LO, 16'sd100);
		write_limit(REG_X_HI, 16'sd100);
		write_limit(REG_Y_LO, -16'sd7);
		write_limit(REG_Y_HI, -16'sd7);
		@(negedge clk);
		queue_sample(100, -7, 0);
		queue_sample(101, -8, 0);
		queue_sample(99, -6, 0);
		queue_sample(100, -7, 1);
		queue_sample(-32768, 32767, 0);
		settle();

		// mirrored x, widest y
		write_limit(REG_X_LO, 16'sd3000);
		write_limit(REG_X_HI, -16'sd3000);
		write_limit(REG_Y_LO, -16'sd32768);
		write_limit(REG_Y_HI, 16'sd32767);
		@(negedge clk);
		queue_sample(1500, 0, 0);
		queue_sample(-3000, -32768, 0);
		queue_sample(32767, 32767, 0);
		settle();

		// widest x, widest mirrored y
		write_limit(REG_X_LO, -16'sd32768);
		write_limit(REG_X_HI, 16'sd32767);
		write_limit(REG_Y_LO, 16'sd32767);
		write_limit(REG_Y_HI, -16'sd32768);
		@(negedge clk);
		queue_sample(0, 0, 0);
		queue_sample(-32768, 32767, 0);
		queue_sample(32767, -32768, 1);
		queue_sample(12345, -12345, 0);
		settle();

		for (ph = 0; ph < 6; ph++) begin
			random_limits(REG_X_LO, REG_X_HI);
			random_limits(REG_Y_LO, REG_Y_HI);
			@(negedge clk);
			idle_on = (ph != 2);
			left = 125;
			while (left > 0) begin
				kind = $urandom_range(0, 19);
				if (kind == 0) begin
					queue_sample(rand16(), rand16(), $urandom_range(0, 1));
					left--;
				end else if (kind < 3) begin
					// hold burst, then the re-centering sample
					burst = $urandom_range(1, 4);
					repeat (burst)
						queue_sample(pick_field(limit_reg[REG_X_LO], limit_reg[REG_X_HI]),
							pick_field(limit_reg[REG_Y_LO], limit_reg[REG_Y_HI]), 1'b1);
					queue_sample(pick_field(limit_reg[REG_X_LO], limit_reg[REG_X_HI]),
						pick_field(limit_reg[REG_Y_LO], limit_reg[REG_Y_HI]), 1'b0);
					left -= burst + 1;
				end else begin
					queue_sample(pick_field(limit_reg[REG_X_LO], limit_reg[REG_X_HI]),
						pick_field(limit_reg[REG_Y_LO], limit_reg[REG_Y_HI]), 1'b0);
					left--;
				end
			end
			settle();
		end

		repeat (100) @(posedge clk);
		if (err_cnt == 0 && expect_q.size() == 0)
			$display("mag_to_pointer_position test passed");
		else
			$display("mag_to_pointer_position test failed");
		$finish;
	end

endmodule
